>>> rtl/core/pcfa_pkg.sv
// shared constants, register indexes and sequencer states of the contact force accumulator
`timescale 1ns / 1ps

package pcfa_pkg;

   // field widths
   localparam int IDX_W   = 16;
   localparam int DATA_W  = 32;
   localparam int DIA_W   = 31;
   localparam int STIFF_W = 20;
   localparam int DAMP_W  = 16;
   localparam int ADDR_W  = 4;

   // shared multiplier and datapath widths
   localparam int MUL_A_W = 37;
   localparam int MUL_B_W = 20;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 64;
   localparam int DIFF_W  = DATA_W + 1;
   localparam int NRM_W   = 17;
   localparam int VN_W    = 34;
   localparam int MAG_W   = 53;
   localparam int CNT_W   = 5;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_DIAMETER  = 2'd0;
   localparam logic [1:0] REG_STIFFNESS = 2'd1;
   localparam logic [1:0] REG_DAMPING   = 2'd2;

   // register reset values
   localparam logic [DIA_W-1:0]   DIA_RESET   = 31'd65536;
   localparam logic [STIFF_W-1:0] STIFF_RESET = 20'd10000;
   localparam logic [DAMP_W-1:0]  DAMP_RESET  = 16'd50;

   // iteration counter start values, counted down to zero
   localparam logic [CNT_W-1:0] ROOT_LAST = 5'd31;
   localparam logic [CNT_W-1:0] DIV_LAST  = 5'd16;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SQ_X0,
      ST_SQ_X1,
      ST_SQ_Y0,
      ST_SQ_Y1,
      ST_DD0,
      ST_DD1,
      ST_TEST,
      ST_ROOT,
      ST_DIV_X,
      ST_DIV_Y,
      ST_DOT_X,
      ST_DOT_Y,
      ST_VN,
      ST_SPRING,
      ST_DAMP,
      ST_MAG,
      ST_SX_LO,
      ST_SX_HI,
      ST_SAT_X,
      ST_SY_LO,
      ST_SY_HI,
      ST_SAT_Y,
      ST_FINISH
   } state_type;

endpackage

>>> rtl/core/particle_contact_force_accumulator_top.sv
// contact force accumulator: sequencer around one shared 37x20 multiplier and add unit
// a contact pair holds the block through 32 square-root steps and 2x17 divide steps, which
// dominate; the rest are single multiply or add steps on the shared unit
// self pair or coordinate gap beyond the diameter ends after the check; coincident or outside circle after the test
// one word at a time; a finished force waits in the output register while the next word enters
// synchronous active-high reset: sums cleared, registers to their defaults, no result pending
`timescale 1ns / 1ps

module particle_contact_force_accumulator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [pcfa_pkg::IDX_W-1:0]   req_own_index,
   input  logic        [pcfa_pkg::IDX_W-1:0]   req_other_index,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_own_pos_x,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_own_pos_y,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_own_vel_x,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_own_vel_y,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_other_pos_x,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_other_pos_y,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_other_vel_x,
   input  logic signed [pcfa_pkg::DATA_W-1:0]  req_other_vel_y,
   input  logic                                req_last_neighbour,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [pcfa_pkg::IDX_W-1:0]   rsp_particle_index,
   output logic signed [pcfa_pkg::DATA_W-1:0]  rsp_force_x,
   output logic signed [pcfa_pkg::DATA_W-1:0]  rsp_force_y,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [pcfa_pkg::ADDR_W-1:0]  paddr,
   input  logic        [pcfa_pkg::DATA_W-1:0]  pwdata,
   output logic        [pcfa_pkg::DATA_W-1:0]  prdata,
   output logic                                pready
);
   import pcfa_pkg::*;

   // control and configuration
   state_type            state_ff, state_in;
   logic [DIA_W-1:0]     dia_ff, dia_in;
   logic [STIFF_W-1:0]   stiff_ff, stiff_in;
   logic [DAMP_W-1:0]    damp_ff, damp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    sum_x_ff, sum_x_in;
   logic [DATA_W-1:0]    sum_y_ff, sum_y_in;

   // captured word
   logic [IDX_W-1:0]     own_ff, own_in;
   logic [IDX_W-1:0]     other_ff, other_in;
   logic                 last_ff, last_in;
   logic [DIFF_W-1:0]    adx_ff, adx_in;
   logic [DIFF_W-1:0]    ady_ff, ady_in;
   logic                 dx_neg_ff, dx_neg_in;
   logic                 dy_neg_ff, dy_neg_in;
   logic [DIFF_W-1:0]    rx_mag_ff, rx_mag_in;
   logic [DIFF_W-1:0]    ry_mag_ff, ry_mag_in;
   logic                 rx_neg_ff, rx_neg_in;
   logic                 ry_neg_ff, ry_neg_in;

   // working registers
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W-1:0]     rem_ff, rem_in;
   logic [ACC_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIA_W-1:0]     drem_ff, drem_in;
   logic [NRM_W-1:0]     quot_ff, quot_in;
   logic [NRM_W-1:0]     num_ff, num_in;
   logic [NRM_W-1:0]     nx_ff, nx_in;
   logic [NRM_W-1:0]     ny_ff, ny_in;
   logic [VN_W-1:0]      vn_mag_ff, vn_mag_in;
   logic                 vn_neg_ff, vn_neg_in;
   logic [MAG_W-1:0]     m_mag_ff, m_mag_in;
   logic                 m_neg_ff, m_neg_in;
   logic [DIFF_W-1:0]    part_ff, part_in;

   // output register
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]    rsp_fx_ff, rsp_fx_in;
   logic [DATA_W-1:0]    rsp_fy_ff, rsp_fy_in;

   // datapath helpers
   logic [DIFF_W-1:0]    dx_w, dy_w, rx_w, ry_w;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic [ACC_W-1:0]     prod;
   logic [ACC_W-1:0]     acc_abs;
   logic [ACC_W-1:0]     root_bit;
   logic [ACC_W-1:0]     root_trial;
   logic [DIA_W-1:0]     root_dist;
   logic [DATA_W-1:0]    div_trial;
   logic                 div_ge;
   logic [ACC_W-1:0]     scaled;
   logic [ACC_W-1:0]     sat_sum;
   logic [DATA_W-1:0]    sat_val;
   logic                 csr_write;
   logic                 rsp_take;

   assign root_dist  = root_ff[DIA_W-1:0];
   assign csr_write  = psel && penable && pwrite;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign pready     = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_particle_index = rsp_index_ff;
   assign rsp_force_x        = rsp_fx_ff;
   assign rsp_force_y        = rsp_fy_ff;

   // differences of the incoming word
   assign dx_w = {req_other_pos_x[DATA_W-1], req_other_pos_x}
               - {req_own_pos_x[DATA_W-1], req_own_pos_x};
   assign dy_w = {req_other_pos_y[DATA_W-1], req_other_pos_y}
               - {req_own_pos_y[DATA_W-1], req_own_pos_y};
   assign rx_w = {req_own_vel_x[DATA_W-1], req_own_vel_x}
               - {req_other_vel_x[DATA_W-1], req_other_vel_x};
   assign ry_w = {req_own_vel_y[DATA_W-1], req_own_vel_y}
               - {req_other_vel_y[DATA_W-1], req_other_vel_y};

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ_X0: begin
            mul_a = MUL_A_W'(adx_ff[DIA_W-1:0]);
            mul_b = MUL_B_W'(adx_ff[15:0]);
         end
         ST_SQ_X1: begin
            mul_a = MUL_A_W'(adx_ff[DIA_W-1:0]);
            mul_b = MUL_B_W'(adx_ff[DIA_W-1:16]);
         end
         ST_SQ_Y0: begin
            mul_a = MUL_A_W'(ady_ff[DIA_W-1:0]);
            mul_b = MUL_B_W'(ady_ff[15:0]);
         end
         ST_SQ_Y1: begin
            mul_a = MUL_A_W'(ady_ff[DIA_W-1:0]);
            mul_b = MUL_B_W'(ady_ff[DIA_W-1:16]);
         end
         ST_DD0: begin
            mul_a = MUL_A_W'(dia_ff);
            mul_b = MUL_B_W'(dia_ff[15:0]);
         end
         ST_DD1: begin
            mul_a = MUL_A_W'(dia_ff);
            mul_b = MUL_B_W'(dia_ff[DIA_W-1:16]);
         end
         ST_DOT_X: begin
            mul_a = MUL_A_W'(rx_mag_ff);
            mul_b = MUL_B_W'(nx_ff);
         end
         ST_DOT_Y: begin
            mul_a = MUL_A_W'(ry_mag_ff);
            mul_b = MUL_B_W'(ny_ff);
         end
         ST_SPRING: begin
            mul_a = MUL_A_W'(dia_ff - root_dist);
            mul_b = stiff_ff;
         end
         ST_DAMP: begin
            mul_a = MUL_A_W'(vn_mag_ff);
            mul_b = MUL_B_W'(damp_ff);
         end
         ST_SX_LO: begin
            mul_a = MUL_A_W'(m_mag_ff[15:0]);
            mul_b = MUL_B_W'(nx_ff);
         end
         ST_SX_HI: begin
            mul_a = m_mag_ff[MAG_W-1:16];
            mul_b = MUL_B_W'(nx_ff);
         end
         ST_SY_LO: begin
            mul_a = MUL_A_W'(m_mag_ff[15:0]);
            mul_b = MUL_B_W'(ny_ff);
         end
         ST_SY_HI: begin
            mul_a = m_mag_ff[MAG_W-1:16];
            mul_b = MUL_B_W'(ny_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   assign prod  = ACC_W'(mul_p);

   // magnitude of the accumulator
   assign acc_abs = acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;

   // square root step
   assign root_bit   = ACC_W'(1) << {cnt_ff, 1'b0};
   assign root_trial = root_ff + root_bit;

   // divide step
   assign div_trial = {drem_ff, num_ff[NRM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, root_dist});

   // high partial product plus the carried low part
   assign scaled = prod + ACC_W'(part_ff[DIFF_W-1:16]);

   // saturating add of the force component in the accumulator
   always_comb begin
      if (state_ff == ST_SAT_Y) begin
         sat_sum = {{(ACC_W-DATA_W){sum_y_ff[DATA_W-1]}}, sum_y_ff} + acc_ff;
      end else begin
         sat_sum = {{(ACC_W-DATA_W){sum_x_ff[DATA_W-1]}}, sum_x_ff} + acc_ff;
      end
      if (!sat_sum[ACC_W-1] && (sat_sum[ACC_W-2:DATA_W-1] != '0)) begin
         sat_val = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sat_sum[ACC_W-1] && (sat_sum[ACC_W-2:DATA_W-1] != '1)) begin
         sat_val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_val = sat_sum[DATA_W-1:0];
      end
   end

   // register read
   always_comb begin
      unique case (paddr[3:2])
         REG_DIAMETER:  prdata = DATA_W'(dia_ff);
         REG_STIFFNESS: prdata = DATA_W'(stiff_ff);
         REG_DAMPING:   prdata = DATA_W'(damp_ff);
         default:       prdata = '0;
      endcase
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      dia_in       = dia_ff;
      stiff_in     = stiff_ff;
      damp_in      = damp_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      own_in       = own_ff;
      other_in     = other_ff;
      last_in      = last_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      dx_neg_in    = dx_neg_ff;
      dy_neg_in    = dy_neg_ff;
      rx_mag_in    = rx_mag_ff;
      ry_mag_in    = ry_mag_ff;
      rx_neg_in    = rx_neg_ff;
      ry_neg_in    = ry_neg_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      drem_in      = drem_ff;
      quot_in      = quot_ff;
      num_in       = num_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      vn_mag_in    = vn_mag_ff;
      vn_neg_in    = vn_neg_ff;
      m_mag_in     = m_mag_ff;
      m_neg_in     = m_neg_ff;
      part_in      = part_ff;
      rsp_index_in = rsp_index_ff;
      rsp_fx_in    = rsp_fx_ff;
      rsp_fy_in    = rsp_fy_ff;

      // configuration write
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_DIAMETER:  dia_in   = pwdata[DIA_W-1:0];
            REG_STIFFNESS: stiff_in = pwdata[STIFF_W-1:0];
            REG_DAMPING:   damp_in  = pwdata[DAMP_W-1:0];
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               own_in    = req_own_index;
               other_in  = req_other_index;
               last_in   = req_last_neighbour;
               dx_neg_in = dx_w[DIFF_W-1];
               dy_neg_in = dy_w[DIFF_W-1];
               rx_neg_in = rx_w[DIFF_W-1];
               ry_neg_in = ry_w[DIFF_W-1];
               adx_in    = dx_w[DIFF_W-1] ? (DIFF_W'(0) - dx_w) : dx_w;
               ady_in    = dy_w[DIFF_W-1] ? (DIFF_W'(0) - dy_w) : dy_w;
               rx_mag_in = rx_w[DIFF_W-1] ? (DIFF_W'(0) - rx_w) : rx_w;
               ry_mag_in = ry_w[DIFF_W-1] ? (DIFF_W'(0) - ry_w) : ry_w;
               state_in  = ST_CHECK;
            end
         end
         // self pair or a coordinate gap beyond the diameter adds nothing
         ST_CHECK: begin
            if ((own_ff == other_ff) || (adx_ff > DIFF_W'(dia_ff))
                  || (ady_ff > DIFF_W'(dia_ff))) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SQ_X0;
            end
         end
         // squared distance in two half-width passes per axis
         ST_SQ_X0: begin
            acc_in   = prod;
            state_in = ST_SQ_X1;
         end
         ST_SQ_X1: begin
            acc_in   = acc_ff + (prod << 16);
            state_in = ST_SQ_Y0;
         end
         ST_SQ_Y0: begin
            acc_in   = acc_ff + prod;
            state_in = ST_SQ_Y1;
         end
         ST_SQ_Y1: begin
            acc_in   = acc_ff + (prod << 16);
            state_in = ST_DD0;
         end
         // squared diameter, squared distance parked for the root
         ST_DD0: begin
            rem_in   = acc_ff;
            acc_in   = prod;
            state_in = ST_DD1;
         end
         ST_DD1: begin
            acc_in   = acc_ff + (prod << 16);
            state_in = ST_TEST;
         end
         // coincident centers or beyond the diameter add nothing
         ST_TEST: begin
            if ((rem_ff == '0) || (rem_ff > acc_ff)) begin
               state_in = ST_FINISH;
            end else begin
               root_in  = '0;
               cnt_in   = ROOT_LAST;
               state_in = ST_ROOT;
            end
         end
         // integer square root, one result bit a step
         ST_ROOT: begin
            if (rem_ff >= root_trial) begin
               rem_in  = rem_ff - root_trial;
               root_in = (root_ff >> 1) + root_bit;
            end else begin
               root_in = root_ff >> 1;
            end
            if (cnt_ff == '0) begin
               drem_in  = {1'b0, adx_ff[DIA_W-1:1]};
               num_in   = {adx_ff[0], {(NRM_W-1){1'b0}}};
               cnt_in   = DIV_LAST;
               state_in = ST_DIV_X;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // unit normal x by restoring division
         ST_DIV_X: begin
            drem_in = div_ge ? DIA_W'(div_trial - {1'b0, root_dist})
                             : div_trial[DIA_W-1:0];
            quot_in = {quot_ff[NRM_W-2:0], div_ge};
            num_in  = num_ff << 1;
            if (cnt_ff == '0) begin
               nx_in    = {quot_ff[NRM_W-2:0], div_ge};
               drem_in  = {1'b0, ady_ff[DIA_W-1:1]};
               num_in   = {ady_ff[0], {(NRM_W-1){1'b0}}};
               cnt_in   = DIV_LAST;
               state_in = ST_DIV_Y;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // unit normal y
         ST_DIV_Y: begin
            drem_in = div_ge ? DIA_W'(div_trial - {1'b0, root_dist})
                             : div_trial[DIA_W-1:0];
            quot_in = {quot_ff[NRM_W-2:0], div_ge};
            num_in  = num_ff << 1;
            if (cnt_ff == '0) begin
               ny_in    = {quot_ff[NRM_W-2:0], div_ge};
               state_in = ST_DOT_X;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // relative velocity along the normal
         ST_DOT_X: begin
            acc_in   = (rx_neg_ff ^ dx_neg_ff) ? (ACC_W'(0) - prod) : prod;
            state_in = ST_DOT_Y;
         end
         ST_DOT_Y: begin
            acc_in   = (ry_neg_ff ^ dy_neg_ff) ? (acc_ff - prod) : (acc_ff + prod);
            state_in = ST_VN;
         end
         ST_VN: begin
            vn_mag_in = acc_abs[VN_W+15:16];
            vn_neg_in = acc_ff[ACC_W-1];
            state_in  = ST_SPRING;
         end
         // spring plus damping magnitude
         ST_SPRING: begin
            acc_in   = prod;
            state_in = ST_DAMP;
         end
         ST_DAMP: begin
            acc_in   = vn_neg_ff ? (acc_ff - prod) : (acc_ff + prod);
            state_in = ST_MAG;
         end
         ST_MAG: begin
            m_mag_in = acc_abs[MAG_W-1:0];
            m_neg_in = acc_ff[ACC_W-1];
            state_in = ST_SX_LO;
         end
         // force x = -(nx * m) / 65536 and add to its sum
         ST_SX_LO: begin
            part_in  = prod[DIFF_W-1:0];
            state_in = ST_SX_HI;
         end
         ST_SX_HI: begin
            acc_in   = (dx_neg_ff == m_neg_ff) ? (ACC_W'(0) - scaled) : scaled;
            state_in = ST_SAT_X;
         end
         ST_SAT_X: begin
            sum_x_in = sat_val;
            state_in = ST_SY_LO;
         end
         // force y
         ST_SY_LO: begin
            part_in  = prod[DIFF_W-1:0];
            state_in = ST_SY_HI;
         end
         ST_SY_HI: begin
            acc_in   = (dy_neg_ff == m_neg_ff) ? (ACC_W'(0) - scaled) : scaled;
            state_in = ST_SAT_Y;
         end
         ST_SAT_Y: begin
            sum_y_in = sat_val;
            state_in = ST_FINISH;
         end
         // emit on the last neighbor once the output register is free
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = own_ff;
               rsp_fx_in    = sum_x_ff;
               rsp_fy_in    = sum_y_ff;
               sum_x_in     = '0;
               sum_y_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dia_ff       <= DIA_RESET;
         stiff_ff     <= STIFF_RESET;
         damp_ff      <= DAMP_RESET;
         rsp_valid_ff <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         dia_ff       <= dia_in;
         stiff_ff     <= stiff_in;
         damp_ff      <= damp_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      own_ff       <= own_in;
      other_ff     <= other_in;
      last_ff      <= last_in;
      adx_ff       <= adx_in;
      ady_ff       <= ady_in;
      dx_neg_ff    <= dx_neg_in;
      dy_neg_ff    <= dy_neg_in;
      rx_mag_ff    <= rx_mag_in;
      ry_mag_ff    <= ry_mag_in;
      rx_neg_ff    <= rx_neg_in;
      ry_neg_ff    <= ry_neg_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      cnt_ff       <= cnt_in;
      drem_ff      <= drem_in;
      quot_ff      <= quot_in;
      num_ff       <= num_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      vn_mag_ff    <= vn_mag_in;
      vn_neg_ff    <= vn_neg_in;
      m_mag_ff     <= m_mag_in;
      m_neg_ff     <= m_neg_in;
      part_ff      <= part_in;
      rsp_index_ff <= rsp_index_in;
      rsp_fx_ff    <= rsp_fx_in;
      rsp_fy_ff    <= rsp_fy_in;
   end

endmodule

>>> bench/tb_particle_contact_force_accumulator_top.sv
// self-checking bench for the contact force accumulator: directed table, random pair runs
`timescale 1ns / 1ps

module tb_particle_contact_force_accumulator_top;
   import pcfa_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]         own_index;
      logic [IDX_W-1:0]         other_index;
      logic signed [DATA_W-1:0] own_pos_x;
      logic signed [DATA_W-1:0] own_pos_y;
      logic signed [DATA_W-1:0] own_vel_x;
      logic signed [DATA_W-1:0] own_vel_y;
      logic signed [DATA_W-1:0] other_pos_x;
      logic signed [DATA_W-1:0] other_pos_y;
      logic signed [DATA_W-1:0] other_vel_x;
      logic signed [DATA_W-1:0] other_vel_y;
      logic                     last_neighbour;
   } pair_word_t;

   typedef struct {
      logic [IDX_W-1:0]         particle_index;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
   } force_word_t;

   typedef struct {
      pair_word_t  pair;
      logic        typed;
      force_word_t want;
   } table_row_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   pair_word_t req;
   logic rsp_valid;
   logic rsp_stall;
   logic [IDX_W-1:0] rsp_particle_index;
   logic signed [DATA_W-1:0] rsp_force_x;
   logic signed [DATA_W-1:0] rsp_force_y;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   // model copy of registers and running sums
   longint unsigned cfg_diameter;
   longint unsigned cfg_stiffness;
   longint unsigned cfg_damping;
   longint sum_fx;
   longint sum_fy;

   force_word_t force_queue[$];
   // typed-in answers from the table; they take over the computed one for that row
   force_word_t typed_queue[$];
   logic typed_flags[$];

   int errors;
   int words_sent;
   int forces_checked;
   int contacts_seen;
   int hold_cycles;
   logic word_taken;

   particle_contact_force_accumulator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_own_index      (req.own_index),
      .req_other_index    (req.other_index),
      .req_own_pos_x      (req.own_pos_x),
      .req_own_pos_y      (req.own_pos_y),
      .req_own_vel_x      (req.own_vel_x),
      .req_own_vel_y      (req.own_vel_y),
      .req_other_pos_x    (req.other_pos_x),
      .req_other_pos_y    (req.other_pos_y),
      .req_other_vel_x    (req.other_vel_x),
      .req_other_vel_y    (req.other_vel_y),
      .req_last_neighbour (req.last_neighbour),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_particle_index (rsp_particle_index),
      .rsp_force_x        (rsp_force_x),
      .rsp_force_y        (rsp_force_y),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d", what, got, want);
   endtask

   function automatic longint unsigned abs64(input longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint clamp_add(input longint s, input longint c);
      longint t;
      t = s + c;
      if (t > 64'sd2147483647) return 64'sd2147483647;
      if (t < -64'sd2147483648) return -64'sd2147483648;
      return t;
   endfunction

   // -(n * m) / 2^16, truncated toward zero
   function automatic longint push_back_force(input longint n, input longint m);
      longint unsigned an, am, p;
      an = abs64(n);
      am = abs64(m);
      p = an * (am >> 16) + ((an * (am & 64'hFFFF)) >> 16);
      return ((n < 0) != (m < 0)) ? longint'(p) : -longint'(p);
   endfunction

   // spring-dashpot contribution of one pair, force word on the last neighbour
   function automatic logic accumulate_contact(input pair_word_t w, output force_word_t f);
      longint dx, dy, rx, ry, nx, ny, vn, m;
      longint unsigned adx, ady, dsq, root_dist, rem, bit_w;
      dx = longint'(w.other_pos_x) - longint'(w.own_pos_x);
      dy = longint'(w.other_pos_y) - longint'(w.own_pos_y);
      rx = longint'(w.own_vel_x) - longint'(w.other_vel_x);
      ry = longint'(w.own_vel_y) - longint'(w.other_vel_y);
      adx = abs64(dx);
      ady = abs64(dy);
      if (w.own_index != w.other_index && adx <= cfg_diameter && ady <= cfg_diameter) begin
         dsq = adx * adx + ady * ady;
         if (dsq != 0 && dsq <= cfg_diameter * cfg_diameter) begin
            // bitwise integer square root
            rem = dsq;
            root_dist = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > rem) bit_w >>= 2;
            while (bit_w != 0) begin
               if (rem >= root_dist + bit_w) begin
                  rem -= root_dist + bit_w;
                  root_dist = (root_dist >> 1) + bit_w;
               end else begin
                  root_dist >>= 1;
               end
               bit_w >>= 2;
            end
            nx = longint'((adx << 16) / root_dist);
            ny = longint'((ady << 16) / root_dist);
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
            vn = (rx * nx + ry * ny) / 65536;
            m = longint'((cfg_diameter - root_dist) * cfg_stiffness)
                + vn * longint'(cfg_damping);
            sum_fx = clamp_add(sum_fx, push_back_force(nx, m));
            sum_fy = clamp_add(sum_fy, push_back_force(ny, m));
            contacts_seen++;
         end
      end
      f.particle_index = w.own_index;
      f.force_x = sum_fx[31:0];
      f.force_y = sum_fy[31:0];
      if (w.last_neighbour) begin
         sum_fx = 0;
         sum_fy = 0;
      end
      return w.last_neighbour;
   endfunction

   // accept and check words on both channels
   always @(posedge clock) begin
      force_word_t f, want;
      if (!reset && req_valid && !req_stall) begin
         word_taken = 1'b1;
         words_sent++;
         if (accumulate_contact(req, f)) begin
            if (typed_flags.size() > 0 && typed_flags.pop_front()) f = typed_queue.pop_front();
            force_queue.push_back(f);
         end else if (typed_flags.size() > 0) begin
            void'(typed_flags.pop_front());
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (force_queue.size() == 0) begin
            report_mismatch("unexpected force word, index", rsp_particle_index, -1);
         end else begin
            want = force_queue.pop_front();
            forces_checked++;
            if (rsp_particle_index !== want.particle_index)
               report_mismatch("particle_index", rsp_particle_index, want.particle_index);
            if (rsp_force_x !== want.force_x)
               report_mismatch("force_x", rsp_force_x, want.force_x);
            if (rsp_force_y !== want.force_y)
               report_mismatch("force_y", rsp_force_y, want.force_y);
         end
      end
   end

   // receiver back-pressure: long hold when asked, else random short stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < 4) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 60)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
      end
   end

   // valid is driven blocking so back-to-back words keep it high without a second update
   task automatic send_word(input pair_word_t w);
      int gap;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req <= w;
      req_valid = 1'b1;
      word_taken = 1'b0;
      do @(negedge clock); while (!word_taken);
      req_valid = 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_idx)
         REG_DIAMETER:  cfg_diameter = value & 32'h7FFF_FFFF;
         REG_STIFFNESS: cfg_stiffness = value & 32'h000F_FFFF;
         REG_DAMPING:   cfg_damping = value & 32'h0000_FFFF;
         default: ;
      endcase
   endtask

   // wait for every force word, then let a skipped or in-flight pair drain
   task automatic drain;
      while (force_queue.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   function automatic pair_word_t build_pair(input int own, input int oth,
         input longint dx, input longint dy, input longint vx, input logic last);
      pair_word_t w;
      w.own_index = 16'(own);
      w.other_index = 16'(oth);
      w.own_pos_x = 32'sd0;
      w.own_pos_y = 32'sd0;
      w.own_vel_x = 32'(vx);
      w.own_vel_y = 32'sd0;
      w.other_pos_x = 32'(dx);
      w.other_pos_y = 32'(dy);
      w.other_vel_x = 32'sd0;
      w.other_vel_y = 32'sd0;
      w.last_neighbour = last;
      return w;
   endfunction

   // random pair near the particle, or plain noise
   function automatic pair_word_t random_pair(input int own, input logic last,
         input logic near);
      pair_word_t w;
      longint span;
      w.own_index = 16'(own);
      w.other_index = ($urandom_range(0, 15) == 0) ? own[15:0] : 16'($urandom);
      w.own_pos_x = $urandom;
      w.own_pos_y = $urandom;
      w.own_vel_x = $urandom;
      w.own_vel_y = $urandom;
      w.other_pos_x = $urandom;
      w.other_pos_y = $urandom;
      w.other_vel_x = $urandom;
      w.other_vel_y = $urandom;
      w.last_neighbour = last;
      if (near) begin
         span = longint'(cfg_diameter) * 5 / 4 + 1;
         w.other_pos_x = w.own_pos_x + 32'(longint'({$urandom, $urandom} >> 2) % (2 * span + 1)
                         - span);
         w.other_pos_y = w.own_pos_y + 32'(longint'({$urandom, $urandom} >> 2) % (2 * span + 1)
                         - span);
         if ($urandom_range(0, 1)) begin
            w.own_vel_x = $signed($urandom) >>> 8;
            w.own_vel_y = $signed($urandom) >>> 8;
            w.other_vel_x = $signed($urandom) >>> 8;
            w.other_vel_y = $signed($urandom) >>> 8;
         end
      end
      return w;
   endfunction

   task automatic random_phase(input int count);
      int own, run, sent;
      sent = 0;
      while (sent < count) begin
         own = $urandom_range(0, 65535);
         run = $urandom_range(1, 8);
         for (int k = 0; k < run; k++) begin
            send_word(random_pair(own, k == run - 1, $urandom_range(0, 9) != 0));
            sent++;
         end
      end
   endtask

   table_row_t stimulus_table[$];

   initial begin
      table_row_t r;
      force_word_t zero_force;
      reset = 1'b1;
      req_valid = 1'b0;
      req = build_pair(0, 0, 0, 0, 0, 1'b0);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_cycles = 0;
      errors = 0;
      words_sent = 0;
      forces_checked = 0;
      contacts_seen = 0;
      cfg_diameter = 64'(DIA_RESET);
      cfg_stiffness = 64'(STIFF_RESET);
      cfg_damping = 64'(DAMP_RESET);
      sum_fx = 0;
      sum_fy = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed rows: typed answers where they are obvious
      zero_force.force_x = 0;
      zero_force.force_y = 0;
      // self pair
      r.pair = build_pair(7, 7, 100, 0, 0, 1'b1);
      r.typed = 1'b1; r.want = zero_force; r.want.particle_index = 7;
      stimulus_table.push_back(r);
      // far pair
      r.pair = build_pair(1, 2, 200000, 0, 0, 1'b1);
      r.typed = 1'b1; r.want = zero_force; r.want.particle_index = 1;
      stimulus_table.push_back(r);
      // coincident centres
      r.pair = build_pair(65535, 0, 0, 0, 12345, 1'b1);
      r.typed = 1'b1; r.want = zero_force; r.want.particle_index = 65535;
      stimulus_table.push_back(r);
      // half overlap along x, no motion
      r.pair = build_pair(3, 4, 32768, 0, 0, 1'b1);
      r.typed = 1'b1; r.want = zero_force; r.want.particle_index = 3;
      r.want.force_x = -32'sd327680000;
      stimulus_table.push_back(r);
      // extreme positions, far apart
      r.pair = build_pair(0, 65535, 0, 0, 0, 1'b1);
      r.pair.own_pos_x = 32'sh8000_0000;
      r.pair.other_pos_x = 32'sh7FFF_FFFF;
      r.pair.own_pos_y = 32'sh7FFF_FFFF;
      r.pair.other_pos_y = 32'sh8000_0000;
      r.typed = 1'b1; r.want = zero_force; r.want.particle_index = 0;
      stimulus_table.push_back(r);
      // predicted rows
      r.typed = 1'b0;
      r.pair = build_pair(9, 10, 65536, 0, 32'sh0001_0000, 1'b1);        // touching, damping only
      stimulus_table.push_back(r);
      r.pair = build_pair(11, 12, -30000, 20000, -32'sh0004_0000, 1'b0); // diagonal contact
      stimulus_table.push_back(r);
      r.pair = build_pair(11, 13, 10, -40000, 32'sh7FFF_FFFF, 1'b0);
      stimulus_table.push_back(r);
      r.pair = build_pair(11, 11, 100, 100, 0, 1'b1);                    // last on a skipped pair
      stimulus_table.push_back(r);
      r.pair = build_pair(20, 21, 65536, 65536, 0, 1'b1);                // inside box, outside circle
      stimulus_table.push_back(r);
      r.pair = build_pair(22, 23, -1, -1, 32'sh8000_0000, 1'b1);
      stimulus_table.push_back(r);

      foreach (stimulus_table[i]) begin
         typed_flags.push_back(stimulus_table[i].typed);
         if (stimulus_table[i].typed) typed_queue.push_back(stimulus_table[i].want);
         send_word(stimulus_table[i].pair);
      end
      drain();

      // default registers, with a long receiver hold while words keep coming
      hold_cycles = 600;
      random_phase(300);
      drain();

      // largest diameter and gains: sums run into saturation
      csr_write(REG_DIAMETER, 32'h7FFF_FFFF);
      csr_write(REG_STIFFNESS, 32'h000F_FFFF);
      csr_write(REG_DAMPING, 32'h0000_FFFF);
      random_phase(280);
      drain();

      // zero diameter and gains
      csr_write(REG_DIAMETER, 32'h0);
      csr_write(REG_STIFFNESS, 32'h0);
      csr_write(REG_DAMPING, 32'h0);
      random_phase(200);
      drain();

      // mid settings
      csr_write(REG_DIAMETER, 32'($urandom_range(1 << 12, 1 << 24)));
      csr_write(REG_STIFFNESS, 32'($urandom_range(0, 20'hF_FFFF)));
      csr_write(REG_DAMPING, 32'($urandom_range(0, 16'hFFFF)));
      random_phase(300);
      drain();

      // back to the reset values, near pairs
      csr_write(REG_DIAMETER, DATA_W'(DIA_RESET));
      csr_write(REG_STIFFNESS, DATA_W'(STIFF_RESET));
      csr_write(REG_DAMPING, DATA_W'(DAMP_RESET));
      random_phase(300);
      drain();

      $display("pairs sent %0d, contacts %0d, force words checked %0d", words_sent,
               contacts_seen, forces_checked);
      $display("register settings: reset, all maximum, all zero, random mid, reset again");
      if (errors == 0 && force_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/pcfa_pkg.sv
rtl/core/particle_contact_force_accumulator_top.sv
bench/tb_particle_contact_force_accumulator_top.sv
